### src/sqv_pkg.sv
// ---------------------------------------------------------------------------
// sqv_pkg: shared constants and helpers of the sprite quad vertex generator
// Angle table of the rotation cells, divider widths, register indexes.
// ---------------------------------------------------------------------------
package sqv_pkg;

  // CORDIC
  localparam int unsigned TRIG_STEPS = 16;
  localparam logic signed [18:0] CORDIC_GAIN = 19'sd39796;
  // atan(2^-i) in 2^32 units per full turn
  localparam logic [29:0] ATAN_TURNS [TRIG_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679839,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861
  };

  // divider: quotient bits resolved by the cell chain
  localparam int unsigned QUO_BITS = 17;

  // register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [2:0] LAST_SLOT = 3'd5;

  // corner used by each slot of the six-vertex run: 0,1,2,0,2,3
  function automatic logic [1:0] corner_of_slot(input logic [2:0] slot);
    logic [1:0] c;
    case (slot)
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

### src/sprite_quad_vertex_generator_unit.sv
// Path: a sprite word passes the cell chain and is then loaded into the output serializer.
// Rate: one vertex word per cycle on the output while out_stall_i is low; the 36-stage
// cell chain holds while its last stage is full and the serializer is still busy.
// The chain: input stage, 16 CORDIC cells, product and corner stages, 17 divider cells.
// Reset: clears the valid line and the serializer; screen size returns to 1920 x 1080.
// ---------------------------------------------------------------------------
// sprite_quad_vertex_generator_unit: rotated sprite quad vertex setup
// Rotates the four corners, maps them to NDC and emits six vertices per sprite.
// ---------------------------------------------------------------------------
module sprite_quad_vertex_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_wdata_i,
  // sprite channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] dest_x_i,
  input  logic signed [15:0] dest_y_i,
  input  logic [15:0]        dest_width_i,
  input  logic [15:0]        dest_height_i,
  input  logic [15:0]        angle_i,
  input  logic [15:0]        source_x_i,
  input  logic [15:0]        source_y_i,
  input  logic [15:0]        source_width_i,
  input  logic [15:0]        source_height_i,
  input  logic [12:0]        texture_width_i,
  input  logic [12:0]        texture_height_i,
  input  logic [31:0]        tint_i,
  // vertex channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] ndc_x_o,
  output logic signed [16:0] ndc_y_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic [31:0]        vertex_tint_o,
  output logic [2:0]         vertex_slot_o,
  output logic               last_vertex_o
);

  localparam int unsigned QB      = sqv_pkg::QUO_BITS;
  localparam int unsigned TS      = sqv_pkg::TRIG_STEPS;
  localparam int unsigned V_STAGE = TS + 2;
  localparam int unsigned N_STAGE = V_STAGE + QB + 1;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        hw;
    logic [15:0]        hh;
    logic [15:0]        sx;
    logic [15:0]        sy;
    logic [15:0]        sw;
    logic [15:0]        sh;
    logic [12:0]        tw;
    logic [12:0]        th;
    logic [1:0]         quad;
    logic [31:0]        tint;
  } side_t;

  typedef struct packed {
    logic [7:0]  nsat;
    logic [7:0]  nneg;
    logic [3:0]  tsat;
    logic [31:0] tint;
  } flag_t;

  // ---------------- configuration ----------------
  logic [11:0] scr_w_q, scr_h_q;
  logic [11:0] den_w, den_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 12'd1920;
      scr_h_q <= 12'd1080;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sqv_pkg::REG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata_i;
        sqv_pkg::REG_SCREEN_HEIGHT: scr_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign den_w = (scr_w_q == 12'd0) ? 12'd1 : scr_w_q;
  assign den_h = (scr_h_q == 12'd0) ? 12'd1 : scr_h_q;

  // ---------------- chain control ----------------
  logic [N_STAGE-1:0] v_q;
  logic               en;
  logic               ser_v_q;
  logic [2:0]         slot_q;
  logic               ser_done;

  assign ser_done   = ser_v_q && !out_stall_i && (slot_q == sqv_pkg::LAST_SLOT);
  assign en         = !v_q[N_STAGE-1] || !ser_v_q || ser_done;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N_STAGE-2:0], in_valid_i};
    end
  end

  // ---------------- input stage ----------------
  side_t              side_q [TS+1];
  logic signed [18:0] cx_w [TS+1];
  logic signed [18:0] cy_w [TS+1];
  logic signed [32:0] cz_w [TS+1];
  logic signed [18:0] x0_q, y0_q;
  logic signed [32:0] z0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q           <= sqv_pkg::CORDIC_GAIN;
      y0_q           <= '0;
      z0_q           <= $signed({3'b000, angle_i[13:0], 16'h0000});
      side_q[0].dx   <= dest_x_i;
      side_q[0].dy   <= dest_y_i;
      side_q[0].hw   <= dest_width_i;
      side_q[0].hh   <= dest_height_i;
      side_q[0].sx   <= source_x_i;
      side_q[0].sy   <= source_y_i;
      side_q[0].sw   <= source_width_i;
      side_q[0].sh   <= source_height_i;
      side_q[0].tw   <= (texture_width_i == 13'd0) ? 13'd1 : texture_width_i;
      side_q[0].th   <= (texture_height_i == 13'd0) ? 13'd1 : texture_height_i;
      side_q[0].quad <= angle_i[15:14];
      side_q[0].tint <= tint_i;
      for (int i = 1; i <= TS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign cx_w[0] = x0_q;
  assign cy_w[0] = y0_q;
  assign cz_w[0] = z0_q;

  // ---------------- CORDIC cells ----------------
  for (genvar i = 0; i < TS; i++) begin : g_cordic
    sqv_cordic_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (cx_w[i]),
      .y_i   (cy_w[i]),
      .z_i   (cz_w[i]),
      .x_o   (cx_w[i+1]),
      .y_o   (cy_w[i+1]),
      .z_o   (cz_w[i+1])
    );
  end

  // quadrant fold
  logic signed [18:0] cs, sn;
  always_comb begin
    case (side_q[TS].quad)
      2'd1:    begin cs = -cy_w[TS]; sn = cx_w[TS];  end
      2'd2:    begin cs = -cx_w[TS]; sn = -cy_w[TS]; end
      2'd3:    begin cs = cy_w[TS];  sn = -cx_w[TS]; end
      default: begin cs = cx_w[TS];  sn = cy_w[TS];  end
    endcase
  end

  // ---------------- product stage ----------------
  logic signed [35:0] hwc_q, hhs_q, hws_q, hhc_q;
  logic signed [18:0] ctr_x_q, ctr_y_q;
  side_t              side_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hwc_q    <= $signed({1'b0, side_q[TS].hw}) * cs;
      hhs_q    <= $signed({1'b0, side_q[TS].hh}) * sn;
      hws_q    <= $signed({1'b0, side_q[TS].hw}) * sn;
      hhc_q    <= $signed({1'b0, side_q[TS].hh}) * cs;
      ctr_x_q  <= $signed({side_q[TS].dx[15], side_q[TS].dx[15], side_q[TS].dx, 1'b0})
                + $signed({3'b000, side_q[TS].hw});
      ctr_y_q  <= $signed({side_q[TS].dy[15], side_q[TS].dy[15], side_q[TS].dy, 1'b0})
                + $signed({3'b000, side_q[TS].hh});
      side_m_q <= side_q[TS];
    end
  end

  // ---------------- corner stage ----------------
  logic signed [39:0] cxe, cye, hwc_e, hhs_e, hws_e, hhc_e;
  logic signed [39:0] vpos [8];
  logic [11:0]        nden [8];
  logic [11:0]        nrem0 [8];
  logic [QB-1:0]      nnum0 [8];
  logic [7:0]         nsat0, nneg0;
  logic [16:0]        tnum [4];
  logic [12:0]        tden [4];
  logic [12:0]        trem0 [4];
  logic [QB-1:0]      tnum0 [4];
  logic [3:0]         tsat0;

  assign cxe   = {{5{ctr_x_q[18]}}, ctr_x_q, 16'h0000};
  assign cye   = {{5{ctr_y_q[18]}}, ctr_y_q, 16'h0000};
  assign hwc_e = {{4{hwc_q[35]}}, hwc_q};
  assign hhs_e = {{4{hhs_q[35]}}, hhs_q};
  assign hws_e = {{4{hws_q[35]}}, hws_q};
  assign hhc_e = {{4{hhc_q[35]}}, hhc_q};

  always_comb begin
    logic signed [39:0] nn, ns, a;
    // corners 0..3: (-w,-h) (w,-h) (w,h) (-w,h) around the center
    vpos[0] = cxe - hwc_e + hhs_e;
    vpos[1] = cxe + hwc_e + hhs_e;
    vpos[2] = cxe + hwc_e - hhs_e;
    vpos[3] = cxe - hwc_e - hhs_e;
    vpos[4] = cye - hws_e - hhc_e;
    vpos[5] = cye + hws_e - hhc_e;
    vpos[6] = cye + hws_e + hhc_e;
    vpos[7] = cye - hws_e + hhc_e;
    for (int l = 0; l < 8; l++) begin
      nden[l] = (l < 4) ? den_w : den_h;
      // floor((2v + 64d) / 128) then floor division by d, done on the biased magnitude
      nn = (vpos[l] <<< 1) + $signed({22'd0, nden[l], 6'd0});
      ns = nn >>> 7;
      nneg0[l] = ns[39];
      a = ns[39] ? (-ns + $signed({28'd0, nden[l]}) - 40'sd1) : ns;
      nsat0[l] = a[32:17] >= {4'd0, nden[l]};
      nrem0[l] = a[28:17];
      nnum0[l] = a[16:0];
    end
  end

  // texture edges: q = floor((num*1024 + size/2) / size)
  always_comb begin
    logic [27:0] a;
    tnum[0] = {1'b0, side_m_q.sx};
    tnum[1] = {1'b0, side_m_q.sx} + {1'b0, side_m_q.sw};
    tnum[2] = {1'b0, side_m_q.sy};
    tnum[3] = {1'b0, side_m_q.sy} + {1'b0, side_m_q.sh};
    for (int l = 0; l < 4; l++) begin
      tden[l]  = (l < 2) ? side_m_q.tw : side_m_q.th;
      a        = {1'b0, tnum[l], 10'd0} + {16'd0, tden[l][12:1]};
      tsat0[l] = {2'b00, a[27:17]} >= tden[l];
      trem0[l] = {2'b00, a[27:17]};
      tnum0[l] = a[16:0];
    end
  end

  // ---------------- divider cells ----------------
  logic [11:0]   nd_w [8][QB+1];
  logic [11:0]   nr_w [8][QB+1];
  logic [QB-1:0] nn_w [8][QB+1];
  logic [QB-1:0] nq_w [8][QB+1];
  logic [12:0]   td_w [4][QB+1];
  logic [12:0]   tr_w [4][QB+1];
  logic [QB-1:0] tn_w [4][QB+1];
  logic [QB-1:0] tq_w [4][QB+1];
  logic [11:0]   nd_q [8];
  logic [11:0]   nr_q [8];
  logic [QB-1:0] nn_q [8];
  logic [12:0]   td_q [4];
  logic [12:0]   tr_q [4];
  logic [QB-1:0] tn_q [4];
  flag_t         flag_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 8; l++) begin
        nd_q[l] <= nden[l];
        nr_q[l] <= nrem0[l];
        nn_q[l] <= nnum0[l];
      end
      for (int l = 0; l < 4; l++) begin
        td_q[l] <= tden[l];
        tr_q[l] <= trem0[l];
        tn_q[l] <= tnum0[l];
      end
      flag_q[0].nsat <= nsat0;
      flag_q[0].nneg <= nneg0;
      flag_q[0].tsat <= tsat0;
      flag_q[0].tint <= side_m_q.tint;
      for (int j = 1; j <= QB; j++) begin
        flag_q[j] <= flag_q[j-1];
      end
    end
  end

  for (genvar l = 0; l < 8; l++) begin : g_ndc_lane
    assign nd_w[l][0] = nd_q[l];
    assign nr_w[l][0] = nr_q[l];
    assign nn_w[l][0] = nn_q[l];
    assign nq_w[l][0] = '0;
    for (genvar c = 0; c < QB; c++) begin : g_cell
      sqv_div_cell #(.DW(12)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (nd_w[l][c]),
        .rem_i (nr_w[l][c]),
        .num_i (nn_w[l][c]),
        .quo_i (nq_w[l][c]),
        .d_o   (nd_w[l][c+1]),
        .rem_o (nr_w[l][c+1]),
        .num_o (nn_w[l][c+1]),
        .quo_o (nq_w[l][c+1])
      );
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_tex_lane
    assign td_w[l][0] = td_q[l];
    assign tr_w[l][0] = tr_q[l];
    assign tn_w[l][0] = tn_q[l];
    assign tq_w[l][0] = '0;
    for (genvar c = 0; c < QB; c++) begin : g_cell
      sqv_div_cell #(.DW(13)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (td_w[l][c]),
        .rem_i (tr_w[l][c]),
        .num_i (tn_w[l][c]),
        .quo_i (tq_w[l][c]),
        .d_o   (td_w[l][c+1]),
        .rem_o (tr_w[l][c+1]),
        .num_o (tn_w[l][c+1]),
        .quo_o (tq_w[l][c+1])
      );
    end
  end

  // ---------------- final mapping ----------------
  logic signed [16:0] nx_fin [4];
  logic signed [16:0] ny_fin [4];
  logic [15:0]        tc_fin [4];

  always_comb begin
    logic [QB-1:0]      qs;
    logic signed [19:0] qv, t;
    for (int l = 0; l < 8; l++) begin
      qs = flag_q[QB].nsat[l] ? {QB{1'b1}} : nq_w[l][QB];
      qv = flag_q[QB].nneg[l] ? -$signed({3'b000, qs}) : $signed({3'b000, qs});
      t  = (l < 4) ? (qv - 20'sd16384) : (20'sd16384 - qv);
      if (t < -20'sd65536) begin
        t = -20'sd65536;
      end else if (t > 20'sd65535) begin
        t = 20'sd65535;
      end
      if (l < 4) begin
        nx_fin[l] = t[16:0];
      end else begin
        ny_fin[l-4] = t[16:0];
      end
    end
    for (int l = 0; l < 4; l++) begin
      tc_fin[l] = (flag_q[QB].tsat[l] || tq_w[l][QB][16]) ? 16'hFFFF : tq_w[l][QB][15:0];
    end
  end

  // ---------------- output serializer ----------------
  logic signed [16:0] nx_q [4];
  logic signed [16:0] ny_q [4];
  logic [15:0]        u0_q, u1_q, v0_q, v1_q;
  logic [31:0]        tint_q;
  logic               ser_load;
  logic [1:0]         corner;

  assign ser_load = en && v_q[N_STAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      slot_q  <= '0;
    end else if (ser_load) begin
      ser_v_q <= 1'b1;
      slot_q  <= '0;
    end else if (ser_done) begin
      ser_v_q <= 1'b0;
    end else if (ser_v_q && !out_stall_i) begin
      slot_q  <= slot_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      for (int k = 0; k < 4; k++) begin
        nx_q[k] <= nx_fin[k];
        ny_q[k] <= ny_fin[k];
      end
      u0_q   <= tc_fin[0];
      u1_q   <= tc_fin[1];
      v0_q   <= tc_fin[2];
      v1_q   <= tc_fin[3];
      tint_q <= flag_q[QB].tint;
    end
  end

  // one vertex word per slot
  assign corner        = sqv_pkg::corner_of_slot(slot_q);
  assign out_valid_o   = ser_v_q;
  assign ndc_x_o       = nx_q[corner];
  assign ndc_y_o       = ny_q[corner];
  assign tex_u_o       = (corner == 2'd1 || corner == 2'd2) ? u1_q : u0_q;
  assign tex_v_o       = corner[1] ? v1_q : v0_q;
  assign vertex_tint_o = tint_q;
  assign vertex_slot_o = slot_q;
  assign last_vertex_o = (slot_q == sqv_pkg::LAST_SLOT);

endmodule

### src/sqv_cordic_cell.sv
// ---------------------------------------------------------------------------
// sqv_cordic_cell: one rotation step of the CORDIC chain
// Rotates (x, y) by +/- atan(2^-STEP) and registers the result.
// ---------------------------------------------------------------------------
module sqv_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [18:0] x_i,
  input  logic signed [18:0] y_i,
  input  logic signed [32:0] z_i,
  output logic signed [18:0] x_o,
  output logic signed [18:0] y_o,
  output logic signed [32:0] z_o
);

  logic signed [18:0] dx, dy;
  logic signed [32:0] da;
  logic signed [18:0] x_q, y_q;
  logic signed [32:0] z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;
  assign da = $signed({3'b000, sqv_pkg::ATAN_TURNS[STEP]});

  // rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[32]) begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - da;
      end else begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + da;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### src/sqv_div_cell.sv
// ---------------------------------------------------------------------------
// sqv_div_cell: one restoring division step
// Brings down one numerator bit, subtracts the divisor if it fits.
// ---------------------------------------------------------------------------
module sqv_div_cell #(
  parameter int unsigned DW = 12
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [DW-1:0]                d_i,
  input  logic [DW-1:0]                rem_i,
  input  logic [sqv_pkg::QUO_BITS-1:0] num_i,
  input  logic [sqv_pkg::QUO_BITS-1:0] quo_i,
  output logic [DW-1:0]                d_o,
  output logic [DW-1:0]                rem_o,
  output logic [sqv_pkg::QUO_BITS-1:0] num_o,
  output logic [sqv_pkg::QUO_BITS-1:0] quo_o
);

  logic [DW:0]                  trial;
  logic [DW:0]                  diff;
  logic                         fits;
  logic [DW-1:0]                d_q, rem_q;
  logic [sqv_pkg::QUO_BITS-1:0] num_q, quo_q;

  assign trial = {rem_i, num_i[sqv_pkg::QUO_BITS-1]};
  assign fits  = trial >= {1'b0, d_i};
  assign diff  = trial - {1'b0, d_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= d_i;
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      num_q <= {num_i[sqv_pkg::QUO_BITS-2:0], 1'b0};
      quo_q <= {quo_i[sqv_pkg::QUO_BITS-2:0], fits};
    end
  end

  assign d_o   = d_q;
  assign rem_o = rem_q;
  assign num_o = num_q;
  assign quo_o = quo_q;

endmodule
